FILE: design/min_tracking_stack_core_assert.svh
// Assertion macros for the min tracking stack core.
// Uses clk and rst_n from the including module's scope.
`ifndef MIN_TRACKING_STACK_CORE_ASSERT_SVH
`define MIN_TRACKING_STACK_CORE_ASSERT_SVH
`ifndef SYNTH
`define MTS_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MTS_ASSERT_NOW(lbl, cond, msg)
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: design/mts_pkg.sv
// Shared constants, codes and types of the min tracking stack.
// No dependencies; every other file but the assertion header imports this package.
package mts_pkg;

  localparam int unsigned MTS_STACK_DEPTH = 64;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned OPC_W           = 2;
  localparam int unsigned STS_W           = 2;

  // opcodes; any other code behaves as a query
  localparam logic [OPC_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OPC_W-1:0] OP_POP  = 2'd1;

  // result status codes
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STS_W-1:0] ST_OVER  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
    logic emit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic pop_ok;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: design/mts_if.sv
// Valid/ready channel interfaces for the stack's input and result words.
// Depends on mts_pkg for field widths.
interface mts_in_if;
  import mts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, opcode, push_value, input ready);
  modport sink   (input valid, opcode, push_value, output ready);
endinterface

interface mts_out_if #(
  parameter int unsigned CNT_W = $clog2(mts_pkg::MTS_STACK_DEPTH + 1)
);
  import mts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic signed [DATA_W-1:0] top_value;
  logic signed [DATA_W-1:0] min_value;
  logic                     is_empty;
  logic [STS_W-1:0]         status;
  logic [CNT_W-1:0]         fill_count;

  modport source (output valid, popped_value, top_value, min_value, is_empty, status,
                  fill_count, input ready);
  modport sink   (input valid, popped_value, top_value, min_value, is_empty, status,
                  fill_count, output ready);
endinterface

FILE: design/mts_ctrl.sv
// Sequencing controller of the min tracking stack.
// Depends on mts_pkg for the state and command/status types.
module mts_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mts_pkg::dp_sts_t sts,
  output mts_pkg::dp_cmd_t cmd
);
  import mts_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        // a pop must refetch the new top and minimum from the stores
        state_nxt = sts.pop_ok ? S_LOAD : S_DONE;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/mts_dp.sv
// Datapath of the min tracking stack: value and minimum stores, counts,
// cached top and minimum, and the result register. Depends on mts_pkg.
module mts_dp #(
  parameter int unsigned STACK_DEPTH = mts_pkg::MTS_STACK_DEPTH,
  parameter int unsigned CNT_W       = $clog2(STACK_DEPTH + 1),
  parameter int unsigned AW          = $clog2(STACK_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mts_pkg::dp_cmd_t                 cmd,
  output mts_pkg::dp_sts_t                 sts,
  input  logic [mts_pkg::OPC_W-1:0]        in_opcode,
  input  logic signed [mts_pkg::DATA_W-1:0] in_push_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [mts_pkg::DATA_W-1:0] out_popped_value,
  output logic signed [mts_pkg::DATA_W-1:0] out_top_value,
  output logic signed [mts_pkg::DATA_W-1:0] out_min_value,
  output logic                             out_is_empty,
  output logic [mts_pkg::STS_W-1:0]        out_status,
  output logic [CNT_W-1:0]                 out_fill_count
);
  import mts_pkg::*;

  logic signed [DATA_W-1:0] vmem [STACK_DEPTH];
  logic signed [DATA_W-1:0] mmem [STACK_DEPTH];

  logic [OPC_W-1:0]         op_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]         vcnt_r;
  logic [CNT_W-1:0]         mcnt_r;
  logic signed [DATA_W-1:0] top_r;
  logic signed [DATA_W-1:0] min_r;
  logic signed [DATA_W-1:0] popped_r;
  logic [STS_W-1:0]         status_r;
  logic signed [DATA_W-1:0] vrd_r;
  logic signed [DATA_W-1:0] mrd_r;
  logic                     out_vld_r;
  logic signed [DATA_W-1:0] o_popped_r;
  logic signed [DATA_W-1:0] o_top_r;
  logic signed [DATA_W-1:0] o_min_r;
  logic                     o_empty_r;
  logic [STS_W-1:0]         o_status_r;
  logic [CNT_W-1:0]         o_fill_r;

  logic             is_push;
  logic             is_pop;
  logic             v_empty;
  logic             v_full;
  logic             m_empty;
  logic             m_room;
  logic             push_ok;
  logic             pop_ok;
  logic             min_push;
  logic             min_drop;
  logic [CNT_W-1:0] mcnt_pop;
  logic [CNT_W-1:0] v_rd_cnt;
  logic [CNT_W-1:0] m_rd_cnt;
  logic [AW-1:0]    v_raddr;
  logic [AW-1:0]    m_raddr;
  logic [STS_W-1:0] status_nxt;

  always_comb begin
    is_push  = (op_r == OP_PUSH);
    is_pop   = (op_r == OP_POP);
    v_empty  = (vcnt_r == '0);
    v_full   = (vcnt_r >= CNT_W'(STACK_DEPTH));
    m_empty  = (mcnt_r == '0);
    m_room   = (mcnt_r < CNT_W'(STACK_DEPTH));
    push_ok  = is_push && !v_full;
    pop_ok   = is_pop && !v_empty;
    min_push = push_ok && (m_empty || (m_room && (val_r <= min_r)));
    min_drop = pop_ok && !m_empty && (min_r == top_r);
    mcnt_pop = min_drop ? (mcnt_r - CNT_W'(1)) : mcnt_r;
    // after a pop the new top sits two below the current count
    v_rd_cnt = vcnt_r - CNT_W'(2);
    m_rd_cnt = mcnt_pop - CNT_W'(1);
    v_raddr  = v_rd_cnt[AW-1:0];
    m_raddr  = m_rd_cnt[AW-1:0];
    if (is_push) begin
      status_nxt = v_full ? ST_OVER : ST_OK;
    end else begin
      status_nxt = v_empty ? ST_UNDER : ST_OK;
    end
    sts.pop_ok   = pop_ok;
    sts.out_free = !out_vld_r || out_ready;
  end

  // stores: write on exec, read every cycle into a register
  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      vmem[vcnt_r[AW-1:0]] <= val_r;
    end
    vrd_r <= vmem[v_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && min_push) begin
      mmem[mcnt_r[AW-1:0]] <= val_r;
    end
    mrd_r <= mmem[m_raddr];
  end

  // counts and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r    <= '0;
      mcnt_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        if (push_ok) begin
          vcnt_r <= vcnt_r + CNT_W'(1);
        end else if (pop_ok) begin
          vcnt_r <= vcnt_r - CNT_W'(1);
        end
        if (min_push) begin
          mcnt_r <= mcnt_r + CNT_W'(1);
        end else if (min_drop) begin
          mcnt_r <= mcnt_pop;
        end
      end
      if (cmd.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      val_r <= in_push_value;
    end
    if (cmd.exec) begin
      popped_r <= pop_ok ? top_r : '0;
      status_r <= status_nxt;
      if (push_ok) begin
        top_r <= val_r;
      end
      if (min_push) begin
        min_r <= val_r;
      end
    end
    if (cmd.load) begin
      top_r <= vrd_r;
      min_r <= mrd_r;
    end
    if (cmd.emit) begin
      o_popped_r <= popped_r;
      o_top_r    <= v_empty ? '0 : top_r;
      o_min_r    <= (v_empty || m_empty) ? '0 : min_r;
      o_empty_r  <= v_empty;
      o_status_r <= status_r;
      o_fill_r   <= vcnt_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_popped_value = o_popped_r;
  assign out_top_value    = o_top_r;
  assign out_min_value    = o_min_r;
  assign out_is_empty     = o_empty_r;
  assign out_status       = o_status_r;
  assign out_fill_count   = o_fill_r;

`include "min_tracking_stack_core_assert.svh"

  `MTS_ASSERT_NOW(a_vcnt_bound, vcnt_r <= CNT_W'(STACK_DEPTH), "value count above depth")
  `MTS_ASSERT_NOW(a_mcnt_le_vcnt, mcnt_r <= vcnt_r, "more minima than values")
  `MTS_ASSERT_NOW(a_min_present, (vcnt_r == '0) || (mcnt_r != '0), "values without a minimum")
  `MTS_ASSERT_NEXT(a_push_top, cmd.exec && push_ok, (top_r == $past(val_r)) && (vcnt_r == CNT_W'($past(vcnt_r) + CNT_W'(1))), "push did not update top")

endmodule

FILE: design/min_tracking_stack_core.sv
// Min tracking stack: LIFO of signed 32-bit words with a constant-time minimum.
// The controller takes a new word only after the previous result has entered the output
// register; a pop adds a load step that refetches top and minimum from the stores.
// Reset: synchronous active low; clears both counts and the result valid.
// The stores are not cleared (no clearing pass); only entries below the counts reach the results.
module min_tracking_stack_core #(
  parameter int unsigned STACK_DEPTH = mts_pkg::MTS_STACK_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  mts_in_if.sink    in_ch,
  mts_out_if.source out_ch
);
  import mts_pkg::*;

  // count holds 0..STACK_DEPTH, store address 0..STACK_DEPTH-1
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW    = $clog2(STACK_DEPTH);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller: accept one word, execute, refetch after a pop, then hand the
  // result to the output register once it is free. The input side can take a
  // new word while the previous result still waits in the output register.
  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: stores, counts, cached top/minimum and the output register.
  mts_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .CNT_W       (CNT_W),
    .AW          (AW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_ch.opcode),
    .in_push_value    (in_ch.push_value),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_popped_value (out_ch.popped_value),
    .out_top_value    (out_ch.top_value),
    .out_min_value    (out_ch.min_value),
    .out_is_empty     (out_ch.is_empty),
    .out_status       (out_ch.status),
    .out_fill_count   (out_ch.fill_count)
  );

endmodule

FILE: sim/tb_min_tracking_stack_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for min_tracking_stack_core: directed and random stack words.
// Depends on mts_pkg, the channel interfaces in mts_if.sv and the core RTL.
module tb_min_tracking_stack_core;
  import mts_pkg::*;

  localparam int unsigned CNT_W = $clog2(MTS_STACK_DEPTH + 1);

  // The package names only push and pop; every other code is a query.
  localparam logic [OPC_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;

  localparam int unsigned RANDOM_WORDS = 700;
  localparam int unsigned MAX_REPORTS  = 200;

  // Random traffic comes in phases that steer the stack depth.
  typedef enum logic [1:0] {
    PH_GROW,
    PH_SHRINK,
    PH_CHURN
  } phase_kind_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped;
    logic signed [DATA_W-1:0] top;
    logic signed [DATA_W-1:0] low;
    logic                     empty;
    logic [STS_W-1:0]         status;
    logic [CNT_W-1:0]         fill;
  } stack_result_t;

  // Shadow stack: tracks values and running minima, queues the result
  // word each accepted command should produce, and checks returned words.
  class stack_scoreboard;
    logic signed [DATA_W-1:0] held_vals [MTS_STACK_DEPTH];
    logic signed [DATA_W-1:0] held_mins [MTS_STACK_DEPTH];
    int unsigned              depth;
    int unsigned              min_depth;
    stack_result_t            pending [$];
    int unsigned              errors;

    function void note_word(logic [OPC_W-1:0] op, logic signed [DATA_W-1:0] v);
      stack_result_t r;
      r = '0;
      r.status = ST_OK;
      if (op == OP_PUSH) begin
        if (depth >= MTS_STACK_DEPTH) begin
          r.status = ST_OVER;
        end else begin
          held_vals[depth] = v;
          depth++;
          if (min_depth == 0) begin
            held_mins[0] = v;
            min_depth = 1;
          end else if (min_depth < MTS_STACK_DEPTH && v <= held_mins[min_depth-1]) begin
            held_mins[min_depth] = v;
            min_depth++;
          end
        end
      end else if (op == OP_POP) begin
        if (depth == 0) begin
          r.status = ST_UNDER;
        end else begin
          depth--;
          r.popped = held_vals[depth];
          if (min_depth != 0 && held_mins[min_depth-1] == r.popped) min_depth--;
        end
      end else if (depth == 0) begin
        r.status = ST_UNDER;
      end
      r.top   = (depth != 0) ? held_vals[depth-1] : '0;
      r.low   = (depth != 0 && min_depth != 0) ? held_mins[min_depth-1] : '0;
      r.empty = (depth == 0);
      r.fill  = CNT_W'(depth);
      pending.push_back(r);
    endfunction

    function void report(string field, logic signed [63:0] e, logic signed [63:0] a);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, e, a);
    endfunction

    function void check_word(stack_result_t got);
      stack_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected, expected none actual top %0d",
                 $time, got.top);
        return;
      end
      exp = pending.pop_front();
      if (got.popped !== exp.popped) report("popped_value", exp.popped, got.popped);
      if (got.top !== exp.top)       report("top_value", exp.top, got.top);
      if (got.low !== exp.low)       report("min_value", exp.low, got.low);
      if (got.empty !== exp.empty)   report("is_empty", exp.empty, got.empty);
      if (got.status !== exp.status) report("status", exp.status, got.status);
      if (got.fill !== exp.fill)     report("fill_count", exp.fill, got.fill);
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mts_in_if  in_ch ();
  mts_out_if out_ch ();

  min_tracking_stack_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  stack_scoreboard sb = new;

  // Quiet flags give stretches with no idling on each side.
  bit src_quiet;
  bit sink_quiet;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // Mix small values (lots of equal minima), the signed extremes and full-range words.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_W'(int'($urandom_range(0, 8)) - 4);
      4: begin
        case ($urandom_range(0, 3))
          0:       return WORD_MIN;
          1:       return WORD_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // Offer one word after a random gap; hold it until the core takes it.
  // Called and returns just after a falling edge.
  task automatic send_word(logic [OPC_W-1:0] op, logic signed [DATA_W-1:0] v);
    int unsigned gap;
    gap = draw_gap(src_quiet);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.opcode     = op;
    in_ch.push_value = v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_word(op, v);
    @(negedge clk);
  endtask

  // Result side: stall at random, twice for a long stretch so the core
  // backs up and holds off the sender; check every word taken.
  initial begin
    int unsigned   gap;
    int unsigned   taken;
    stack_result_t got;
    taken        = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) sink_quiet = ($urandom_range(0, 2) == 0);
      gap = draw_gap(sink_quiet);
      if (taken == 120 || taken == 450) gap = 300;
      if (gap != 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.popped = out_ch.popped_value;
      got.top    = out_ch.top_value;
      got.low    = out_ch.min_value;
      got.empty  = out_ch.is_empty;
      got.status = out_ch.status;
      got.fill   = out_ch.fill_count;
      sb.check_word(got);
      taken++;
      @(negedge clk);
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned len;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned r;
    phase_kind_t kind;
    logic [OPC_W-1:0] op;

    in_ch.valid      = 1'b0;
    in_ch.opcode     = OP_PUSH;
    in_ch.push_value = '0;
    src_quiet        = 1'b0;
    rst_n            = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Underflow on an empty stack: pop, query and the spare code.
    send_word(OP_POP, WORD_MAX);
    send_word(OP_QUERY, '0);
    send_word(OP_SPARE, WORD_MIN);
    // Signed order at the extremes, and a repeated minimum.
    send_word(OP_PUSH, 32'sd5);
    send_word(OP_PUSH, WORD_MAX);
    send_word(OP_PUSH, WORD_MIN);
    send_word(OP_PUSH, WORD_MIN);
    send_word(OP_QUERY, '1);
    send_word(OP_SPARE, '0);
    send_word(OP_POP, '0);
    send_word(OP_POP, '0);
    send_word(OP_POP, '0);
    // Equal value becomes a new minimum; -1 against 0 checks the sign.
    send_word(OP_PUSH, 32'sd5);
    send_word(OP_PUSH, 32'sd7);
    send_word(OP_PUSH, -32'sd1);
    send_word(OP_PUSH, 32'sd0);
    send_word(OP_POP, '0);
    send_word(OP_POP, '0);
    send_word(OP_POP, '0);
    send_word(OP_POP, '0);
    send_word(OP_POP, '0);
    // The stack is now empty: underflow again on pop and query.
    send_word(OP_POP, '0);
    send_word(OP_QUERY, '0);

    // Random phases; the first one fills the stack past full to force overflow.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_WORDS) begin
      if (phase == 0) begin
        kind = PH_GROW;
        len  = MTS_STACK_DEPTH + 8;
      end else begin
        kind = phase_kind_t'($urandom_range(0, 2));
        len  = $urandom_range(20, 90);
      end
      case (kind)
        PH_GROW:   begin push_pct = (phase == 0) ? 100 : 90; pop_pct = 5;  end
        PH_SHRINK: begin push_pct = 15;                      pop_pct = 75; end
        default:   begin push_pct = 45;                      pop_pct = 35; end
      endcase
      repeat (len) begin
        if (sent % 40 == 0) src_quiet = ($urandom_range(0, 2) == 0);
        r = $urandom_range(0, 99);
        if (r < push_pct)                op = OP_PUSH;
        else if (r < push_pct + pop_pct) op = OP_POP;
        else                             op = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_QUERY;
        send_word(op, pick_value());
        sent++;
      end
      phase++;
    end
    in_ch.valid = 1'b0;

    // Drain: wait for every expected word, then keep watching for stray words.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
